// ----- sv/wsp_pkg.sv -----
`timescale 1ns / 1ps
package wsp_pkg;

    localparam int SCREEN_WIDTH  = 160;
    localparam int SCREEN_HEIGHT = 120;
    localparam int ANGLE_STEPS   = 360;
    localparam int QUARTER_TURN  = ANGLE_STEPS / 4;
    localparam int FOCAL         = 200;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEWER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEWER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEWER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH    = 3'd4;

    localparam int XW = 18;
    localparam int ZW = 22;

    localparam int CLIP_NW = 34;
    localparam int CLIP_DW = 19;
    localparam int CLIP_QW = 16;
    localparam int PROJ_NW = 27;
    localparam int PROJ_DW = 18;
    localparam int PROJ_QW = 27;
    localparam int NUM_PROJ = 6;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam longint unsigned PI_Q28 = 64'd843314857;

    typedef logic [14:0] t_quarter [0:90];

    function automatic t_quarter build_quarter();
        t_quarter q;
        longint unsigned x;
        longint unsigned t;
        longint unsigned s;
        for (int k = 0; k <= 90; k++) begin
            x = (64'(k) * PI_Q28 + 64'd90) / 64'd180;
            t = x;
            s = x;
            for (int n = 1; n <= 8; n++) begin
                t = (t * x) >> 28;
                t = (t * x) >> 28;
                case (n)
                    1: t = t / 64'd6;
                    2: t = t / 64'd20;
                    3: t = t / 64'd42;
                    4: t = t / 64'd72;
                    5: t = t / 64'd110;
                    6: t = t / 64'd156;
                    7: t = t / 64'd210;
                    8: t = t / 64'd272;
                    default: t = t;
                endcase
                if (n % 2 == 1) begin
                    s = s - t;
                end else begin
                    s = s + t;
                end
            end
            q[k] = 15'((s * 64'd16384 + (64'd1 << 27)) >> 28);
        end
        return q;
    endfunction

    localparam t_quarter SIN_QUARTER = build_quarter();

    function automatic logic signed [15:0] sin_q14(input logic [8:0] a);
        logic [8:0] r;
        logic neg;
        logic signed [15:0] m;
        if (a <= 9'(QUARTER_TURN)) begin
            r   = a;
            neg = 1'b0;
        end else if (a <= 9'(2 * QUARTER_TURN)) begin
            r   = 9'(2 * QUARTER_TURN) - a;
            neg = 1'b0;
        end else if (a <= 9'(3 * QUARTER_TURN)) begin
            r   = a - 9'(2 * QUARTER_TURN);
            neg = 1'b1;
        end else begin
            r   = 9'(ANGLE_STEPS) - a;
            neg = 1'b1;
        end
        m = $signed({1'b0, SIN_QUARTER[r[6:0]]});
        return neg ? -m : m;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [28:0] v);
        if (v > 29'sd32767) begin
            return 16'sh7fff;
        end else if (v < -29'sd32768) begin
            return 16'sh8000;
        end
        return 16'(v);
    endfunction

    typedef struct packed {
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic signed [15:0] base_height;
        logic        [11:0] wall_height;
    } t_seg;

    typedef struct packed {
        logic               visible;
        logic signed [15:0] left_screen_x;
        logic signed [15:0] right_screen_x;
        logic signed [15:0] left_bottom_y;
        logic signed [15:0] right_bottom_y;
        logic signed [15:0] left_top_y;
        logic signed [15:0] right_top_y;
    } t_res;

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
        logic        [8:0]  heading;
        logic signed [7:0]  pitch;
    } t_view;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] zb;
        logic signed [ZW-1:0] zt;
    } t_vpt;

    typedef struct packed {
        logic vis;
        logic clip;
        logic swap;
        t_vpt a;
        t_vpt b;
    } t_entry;

endpackage

// ----- sv/wsp_stream_if.sv -----
`timescale 1ns / 1ps
interface wsp_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/wsp_div.sv -----
`timescale 1ns / 1ps
module wsp_div #(
    parameter int NW = 27,
    parameter int DW = 18,
    parameter int QW = 27
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic          i_neg,
    output logic [QW-1:0] o_quo,
    output logic          o_neg
);
    localparam int TW = DW + QW;

    logic [TW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];
    logic [QW-1:0] r_neg;

    logic [TW-1:0] src_rem [QW];
    logic [DW-1:0] src_den [QW];
    logic [QW-1:0] src_quo [QW];
    logic [TW-1:0] n_rem [QW];
    logic [QW-1:0] n_quo [QW];

    always_comb begin
        src_rem[0] = TW'(i_num);
        src_den[0] = i_den;
        src_quo[0] = '0;
        for (int k = 1; k < QW; k++) begin
            src_rem[k] = r_rem[k-1];
            src_den[k] = r_den[k-1];
            src_quo[k] = r_quo[k-1];
        end
    end

    always_comb begin : p_step
        logic [TW-1:0] shd;
        for (int k = 0; k < QW; k++) begin
            shd = TW'(src_den[k]) << (QW - 1 - k);
            if (src_rem[k] >= shd) begin
                n_rem[k] = src_rem[k] - shd;
                n_quo[k] = src_quo[k] | (QW'(1) << (QW - 1 - k));
            end else begin
                n_rem[k] = src_rem[k];
                n_quo[k] = src_quo[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= src_den[k];
                r_quo[k] <= n_quo[k];
            end
            r_neg <= {r_neg[QW-2:0], i_neg};
        end
    end

    assign o_quo = r_quo[QW-1];
    assign o_neg = r_neg[QW-1];
endmodule

// ----- sv/wsp_front.sv -----
`timescale 1ns / 1ps
module wsp_front import wsp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_view             i_view,
    wsp_stream_if.sink        i_seg,
    output logic              o_valid,
    output t_entry            o_entry,
    input  logic              i_ready
);
    logic       en;
    logic [4:0] r_v;
    logic [8:0] hdg;
    logic [8:0] cidx;

    logic signed [15:0] r_sin, r_cos;
    logic signed [16:0] r_dx0, r_dy0, r_dx1, r_dy1;
    logic signed [16:0] r_bz1, r_bz2, r_bz3, r_bz4;
    logic        [11:0] r_h1, r_h2, r_h3, r_h4;
    logic signed [32:0] r_xc0, r_ys0, r_yc0, r_xs0;
    logic signed [32:0] r_xc1, r_ys1, r_yc1, r_xs1;
    logic signed [XW-1:0] r_wx0, r_wy0, r_wx1, r_wy1;
    logic signed [XW-1:0] r_wx0_4, r_wy0_4, r_wx1_4, r_wy1_4;
    logic signed [25:0] r_m0, r_m1;
    t_entry r_ent;

    logic signed [26:0] num0, num1;
    t_vpt   p0, p1;
    logic   n0, n1;
    t_entry n_ent;

    assign en          = !r_v[4] || i_ready;
    assign i_seg.ready = en;
    assign o_valid     = r_v[4];
    assign o_entry     = r_ent;

    always_comb begin
        hdg  = (i_view.heading >= 9'(ANGLE_STEPS)) ? i_view.heading - 9'(ANGLE_STEPS)
                                                   : i_view.heading;
        cidx = (hdg >= 9'(3 * QUARTER_TURN)) ? hdg - 9'(3 * QUARTER_TURN)
                                             : hdg + 9'(QUARTER_TURN);
    end

    always_ff @(posedge i_clk) begin
        r_sin <= sin_q14(hdg);
        r_cos <= sin_q14(cidx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[3:0], i_seg.valid};
        end
    end

    always_comb begin
        num0 = 27'(r_bz4) * 27'sd32 + 27'(r_m0);
        num1 = 27'(r_bz4) * 27'sd32 + 27'(r_m1);
        p0.x  = r_wx0_4;
        p0.y  = r_wy0_4;
        p0.zb = ZW'(num0 / 27'sd32);
        p0.zt = p0.zb + ZW'(r_h4);
        p1.x  = r_wx1_4;
        p1.y  = r_wy1_4;
        p1.zb = ZW'(num1 / 27'sd32);
        p1.zt = p1.zb + ZW'(r_h4);
        n0 = r_wy0_4 < 18'sd1;
        n1 = r_wy1_4 < 18'sd1;
        n_ent.vis  = !(n0 && n1);
        n_ent.clip = n0 != n1;
        n_ent.swap = !n0 && n1;
        n_ent.a    = n_ent.swap ? p1 : p0;
        n_ent.b    = n_ent.swap ? p0 : p1;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx0 <= 17'($signed(i_seg.data.start_x)) - 17'(i_view.vx);
            r_dy0 <= 17'($signed(i_seg.data.start_y)) - 17'(i_view.vy);
            r_dx1 <= 17'($signed(i_seg.data.end_x)) - 17'(i_view.vx);
            r_dy1 <= 17'($signed(i_seg.data.end_y)) - 17'(i_view.vy);
            r_bz1 <= 17'($signed(i_seg.data.base_height)) - 17'(i_view.vz);
            r_h1  <= i_seg.data.wall_height;

            r_xc0 <= 33'(r_dx0) * 33'(r_cos);
            r_ys0 <= 33'(r_dy0) * 33'(r_sin);
            r_yc0 <= 33'(r_dy0) * 33'(r_cos);
            r_xs0 <= 33'(r_dx0) * 33'(r_sin);
            r_xc1 <= 33'(r_dx1) * 33'(r_cos);
            r_ys1 <= 33'(r_dy1) * 33'(r_sin);
            r_yc1 <= 33'(r_dy1) * 33'(r_cos);
            r_xs1 <= 33'(r_dx1) * 33'(r_sin);
            r_bz2 <= r_bz1;
            r_h2  <= r_h1;

            r_wx0 <= XW'((34'(r_xc0) - 34'(r_ys0)) / 34'sd16384);
            r_wy0 <= XW'((34'(r_yc0) + 34'(r_xs0)) / 34'sd16384);
            r_wx1 <= XW'((34'(r_xc1) - 34'(r_ys1)) / 34'sd16384);
            r_wy1 <= XW'((34'(r_yc1) + 34'(r_xs1)) / 34'sd16384);
            r_bz3 <= r_bz2;
            r_h3  <= r_h2;

            r_m0    <= 26'(r_wy0) * 26'($signed(i_view.pitch));
            r_m1    <= 26'(r_wy1) * 26'($signed(i_view.pitch));
            r_wx0_4 <= r_wx0;
            r_wy0_4 <= r_wy0;
            r_wx1_4 <= r_wx1;
            r_wy1_4 <= r_wy1;
            r_bz4   <= r_bz3;
            r_h4    <= r_h3;

            r_ent <= n_ent;
        end
    end
endmodule

// ----- sv/wsp_queue.sv -----
`timescale 1ns / 1ps
module wsp_queue import wsp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_entry i_entry,
    output logic   o_ready,
    output logic   o_valid,
    output t_entry o_entry,
    input  logic   i_ready
);
    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QPTR_W:0]     r_cnt;
    logic                push, pop;

    assign o_ready = r_cnt != (QPTR_W + 1)'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_entry = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// ----- sv/wsp_back.sv -----
`timescale 1ns / 1ps
module wsp_back import wsp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_entry      i_entry,
    output logic        o_ready,
    wsp_stream_if.source o_res
);
    logic eb;

    logic                 r_v1, r_v2, r_v3, r_v4;
    t_entry               r_e1, r_e2;
    logic [CLIP_NW-1:0]   r_cnum;
    logic [CLIP_DW-1:0]   r_cden;
    logic [CLIP_QW-1:0]   r_vd1;
    t_entry               r_ed [CLIP_QW];
    logic [CLIP_QW-1:0]   s_quo;
    logic                 s_neg;

    logic signed [39:0]   r_px, r_py, r_pzb, r_pzt;
    t_vpt                 r_p0, r_p1;
    logic                 r_vis3, r_vis4;

    logic [PROJ_NW-1:0]   r_mag [NUM_PROJ];
    logic [NUM_PROJ-1:0]  r_neg;
    logic [PROJ_DW-1:0]   r_den0, r_den1;
    logic [PROJ_QW-1:0]   quo [NUM_PROJ];
    logic [NUM_PROJ-1:0]  qneg;
    logic [PROJ_QW-1:0]   r_vd2;
    logic [PROJ_QW-1:0]   r_visd;

    logic                 r_ov;
    t_res                 r_out;

    logic signed [18:0]   nya;
    logic [CLIP_DW-1:0]   n_cden;
    logic signed [16:0]   ss;
    t_entry               ec;
    t_vpt                 la, na;
    logic signed [ZW-1:0] pv [NUM_PROJ];
    logic signed [29:0]   prod [NUM_PROJ];
    logic signed [15:0]   sc [NUM_PROJ];
    logic signed [28:0]   qv;
    t_res                 n_out;

    function automatic logic signed [ZW-1:0] lerp(input logic signed [ZW-1:0] a,
                                                 input logic signed [39:0] p);
        logic signed [40:0] t;
        t = (41'(a) * 41'sd65536 + 41'(p)) / 41'sd65536;
        return ZW'(t);
    endfunction

    assign eb          = !r_ov || o_res.ready;
    assign o_ready     = eb;
    assign o_res.valid = r_ov;
    assign o_res.data  = r_out;

    always_comb begin
        nya    = -19'(i_entry.a.y);
        n_cden = CLIP_DW'(19'(i_entry.b.y) - 19'(i_entry.a.y));
        if (n_cden == '0) begin
            n_cden = CLIP_DW'(1);
        end
    end

    always_comb begin
        ec = r_ed[CLIP_QW-1];
        ss = $signed({1'b0, s_quo});
    end

    always_comb begin
        la.x  = XW'(lerp(ZW'(r_e2.a.x), r_px));
        la.y  = XW'(lerp(ZW'(r_e2.a.y), r_py));
        if (la.y < 18'sd1) begin
            la.y = 18'sd1;
        end
        la.zb = lerp(r_e2.a.zb, r_pzb);
        la.zt = lerp(r_e2.a.zt, r_pzt);
        na    = r_e2.clip ? la : r_e2.a;
    end

    always_comb begin
        pv[0] = ZW'(r_p0.x);
        pv[1] = ZW'(r_p1.x);
        pv[2] = r_p0.zb;
        pv[3] = r_p1.zb;
        pv[4] = r_p0.zt;
        pv[5] = r_p1.zt;
        for (int j = 0; j < NUM_PROJ; j++) begin
            prod[j] = 30'(pv[j]) * 30'(FOCAL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_vd1 <= '0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_vd2 <= '0;
            r_ov  <= 1'b0;
        end else if (eb) begin
            r_v1  <= i_valid;
            r_vd1 <= {r_vd1[CLIP_QW-2:0], r_v1};
            r_v2  <= r_vd1[CLIP_QW-1];
            r_v3  <= r_v2;
            r_v4  <= r_v3;
            r_vd2 <= {r_vd2[PROJ_QW-2:0], r_v4};
            r_ov  <= r_vd2[PROJ_QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (eb) begin
            r_e1   <= i_entry;
            r_cnum <= {nya[17:0], 16'b0};
            r_cden <= n_cden;

            r_ed[0] <= r_e1;
            for (int k = 1; k < CLIP_QW; k++) begin
                r_ed[k] <= r_ed[k-1];
            end

            r_e2  <= ec;
            r_px  <= 40'(ss) * 40'(23'(ec.b.x) - 23'(ec.a.x));
            r_py  <= 40'(ss) * 40'(23'(ec.b.y) - 23'(ec.a.y));
            r_pzb <= 40'(ss) * 40'(23'(ec.b.zb) - 23'(ec.a.zb));
            r_pzt <= 40'(ss) * 40'(23'(ec.b.zt) - 23'(ec.a.zt));

            r_p0   <= r_e2.swap ? r_e2.b : na;
            r_p1   <= r_e2.swap ? na : r_e2.b;
            r_vis3 <= r_e2.vis;

            for (int j = 0; j < NUM_PROJ; j++) begin
                r_neg[j] <= prod[j] < 30'sd0;
                r_mag[j] <= PROJ_NW'((prod[j] < 30'sd0) ? -prod[j] : prod[j]);
            end
            r_den0 <= PROJ_DW'(r_p0.y);
            r_den1 <= PROJ_DW'(r_p1.y);
            r_vis4 <= r_vis3;

            r_visd <= {r_visd[PROJ_QW-2:0], r_vis4};
            r_out  <= n_out;
        end
    end

    wsp_div #(
        .NW (CLIP_NW),
        .DW (CLIP_DW),
        .QW (CLIP_QW)
    ) u_clip_div (
        .i_clk (i_clk),
        .i_en  (eb),
        .i_num (r_cnum),
        .i_den (r_cden),
        .i_neg (1'b0),
        .o_quo (s_quo),
        .o_neg (s_neg)
    );

    for (genvar j = 0; j < NUM_PROJ; j++) begin : g_proj
        wsp_div #(
            .NW (PROJ_NW),
            .DW (PROJ_DW),
            .QW (PROJ_QW)
        ) u_proj_div (
            .i_clk (i_clk),
            .i_en  (eb),
            .i_num (r_mag[j]),
            .i_den ((j % 2 == 0) ? r_den0 : r_den1),
            .i_neg (r_neg[j]),
            .o_quo (quo[j]),
            .o_neg (qneg[j])
        );
    end

    always_comb begin
        for (int j = 0; j < NUM_PROJ; j++) begin
            qv = $signed(29'(quo[j]));
            if (qneg[j]) begin
                qv = -qv;
            end
            if (j < 2) begin
                qv = qv + 29'(SCREEN_WIDTH / 2);
            end else begin
                qv = qv + 29'(SCREEN_HEIGHT / 2);
            end
            sc[j] = (r_visd[PROJ_QW-1] && !s_neg) ? sat16(qv) : 16'sd0;
        end
        n_out.visible        = r_visd[PROJ_QW-1];
        n_out.left_screen_x  = sc[0];
        n_out.right_screen_x = sc[1];
        n_out.left_bottom_y  = sc[2];
        n_out.right_bottom_y = sc[3];
        n_out.left_top_y     = sc[4];
        n_out.right_top_y    = sc[5];
    end
endmodule

// ----- sv/wall_segment_projection.sv -----
`timescale 1ns / 1ps
// Projects one wall segment a transfer onto the screen with near-plane clipping.
// Segments arrive on i_seg and results leave on o_res; both are valid/ready
// channels and a transfer happens on a clock edge with valid and ready high.
// The viewer position, heading and pitch are written through i_cfg_we,
// i_cfg_idx and i_cfg_data, and are meant to change only while the block is idle.
// One segment is taken every cycle unless a full queue holds the front end. A segment
// passes through the front-end stages, the queue, the 16-stage clip-ratio divider,
// the 27-stage projection dividers, one quotient bit per stage, and five
// further back-end stages before it shows up on o_res.
// The front end and the back end are parted by a four-entry queue, so the
// front end keeps taking segments while the queue has room. When the receiver
// holds ready low, the back end and its dividers freeze and the result stays
// on o_res. Reset empties the pipeline and the queue and loads the default
// viewer registers; the sine table is constant and needs no loading.
module wall_segment_projection import wsp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    wsp_stream_if.sink           i_seg,
    wsp_stream_if.source         o_res
);
    t_view  r_view;
    logic   f_valid, f_ready;
    t_entry f_entry;
    logic   q_valid, q_ready;
    t_entry q_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view.vx      <= 16'sd70;
            r_view.vy      <= -16'sd110;
            r_view.vz      <= 16'sd20;
            r_view.heading <= '0;
            r_view.pitch   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VIEWER_X: r_view.vx      <= i_cfg_data;
                CFG_VIEWER_Y: r_view.vy      <= i_cfg_data;
                CFG_VIEWER_Z: r_view.vz      <= i_cfg_data;
                CFG_HEADING:  r_view.heading <= i_cfg_data[8:0];
                CFG_PITCH:    r_view.pitch   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    wsp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_view  (r_view),
        .i_seg   (i_seg),
        .o_valid (f_valid),
        .o_entry (f_entry),
        .i_ready (f_ready)
    );

    wsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_entry (f_entry),
        .o_ready (f_ready),
        .o_valid (q_valid),
        .o_entry (q_entry),
        .i_ready (q_ready)
    );

    wsp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_entry (q_entry),
        .o_ready (q_ready),
        .o_res   (o_res)
    );
endmodule
